/* sv/dide_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dide_pkg
// shared types, character codes and key name table for the device id
// field extractor
// ----------------------------------------------------------------------------
package dide_pkg;

	localparam int NAME_CNT = 7;
	localparam int KEY_SAT  = 12;
	localparam int KEY_W    = 4;
	localparam int NAME_W   = 8 * KEY_SAT;

	typedef enum logic [1:0] {
		TAG_NONE = 2'd0,
		TAG_MFG  = 2'd1,
		TAG_MDL  = 2'd2,
		TAG_SERN = 2'd3
	} tag_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// names left-aligned, unused tail bytes zero
	localparam logic [NAME_W-1:0] NAME_TEXT [NAME_CNT] = '{
		NAME_W'("MANUFACTURER"),
		{24'("MFG"), 72'd0},
		{40'("MODEL"), 56'd0},
		{24'("MDL"), 72'd0},
		NAME_W'("SERIALNUMBER"),
		{32'("SERN"), 64'd0},
		{16'("SN"), 80'd0}
	};

	localparam logic [KEY_W-1:0] NAME_LEN [NAME_CNT] = '{
		4'd12, 4'd3, 4'd5, 4'd3, 4'd12, 4'd4, 4'd2
	};

	localparam logic [KEY_W-1:0] KEY_SAT_V = KEY_W'(KEY_SAT);

	// character of name idx at position pos (pos below KEY_SAT)
	function automatic logic [7:0] name_char(input int idx, input logic [KEY_W-1:0] pos);
		logic [NAME_W-1:0] txt;
		txt = NAME_TEXT[idx];
		return txt[NAME_W - 1 - 8 * int'(pos) -: 8];
	endfunction

endpackage

/* sv/device_id_field_extractor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_id_field_extractor_unit
// tags each byte of a device id string as manufacturer, model or serial
// value and reports the fields found on the last byte
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                               | tuser / tlast
//  s_axis   | in        | in_byte                             | tlast = is_last
//  m_axis   | out       | out_byte, found_mfg/mdl/sern, id_cpl| tuser = tag, valid, end
//
//  one item per cycle unless stalled; each result is registered when its byte is taken
//  the key scan state and found flags sit in flops updated on every accept,
//  with a single result register on the output side
//  s_axis_tready falls only while a result is held and m_axis_tready is low
//  arst_n clears the scan state, found flags and the output valid
// ----------------------------------------------------------------------------
module device_id_field_extractor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] found_mfg, [9] found_mdl,
	                                    // [10] found_sern, [11] id_complete, [15:12] zero
	output logic [3:0]  m_axis_tuser,   // [1:0] field_tag, [2] value_valid, [3] value_end
	output logic        m_axis_tlast
);
	import dide_pkg::*;

	logic                in_value_q;
	logic [KEY_W-1:0]    key_len_q;
	logic [NAME_CNT-1:0] match_q;
	tag_t                cur_tag_q;
	logic [2:0]          flags_q;

	logic                in_value_d;
	logic [KEY_W-1:0]    key_len_d;
	logic [NAME_CNT-1:0] match_d;
	tag_t                cur_tag_d;
	logic [2:0]          flags_d;

	tag_t       tag_d;
	logic       valid_d, end_d;
	logic [7:0] upper_c;
	logic [NAME_CNT-1:0] hit;
	tag_t       kind;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	tag_t       out_tag_q;
	logic       out_vval_q, out_vend_q, out_last_q, out_cpl_q;
	logic [2:0] out_flags_q;

	logic s_accept;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_comb begin
		for (int i = 0; i < NAME_CNT; i++) begin
			hit[i] = match_q[i] && (key_len_q >= NAME_LEN[i]);
		end
		if (!flags_q[0] && (hit[0] || hit[1])) begin
			kind = TAG_MFG;
		end else if (!flags_q[1] && (hit[2] || hit[3])) begin
			kind = TAG_MDL;
		end else if (!flags_q[2] && (hit[4] || hit[5] || hit[6])) begin
			kind = TAG_SERN;
		end else begin
			kind = TAG_NONE;
		end
		if (s_axis_tdata >= CH_LOW_A && s_axis_tdata <= CH_LOW_Z) begin
			upper_c = s_axis_tdata - CASE_OFS;
		end else begin
			upper_c = s_axis_tdata;
		end
	end

	always_comb begin
		in_value_d = in_value_q;
		key_len_d  = key_len_q;
		match_d    = match_q;
		cur_tag_d  = cur_tag_q;
		flags_d    = flags_q;
		tag_d      = TAG_NONE;
		valid_d    = 1'b0;
		end_d      = 1'b0;
		if (s_axis_tlast && s_axis_tdata == CH_LF) begin
			// trailing newline is dropped but still closes an open value
			if (in_value_q && cur_tag_q != TAG_NONE) begin
				end_d = 1'b1;
				tag_d = cur_tag_q;
			end
		end else if (!in_value_q) begin
			if (s_axis_tdata == CH_COLON) begin
				if (kind != TAG_NONE) begin
					flags_d[2'(kind) - 2'd1] = 1'b1;
				end
				cur_tag_d  = kind;
				in_value_d = 1'b1;
				if (s_axis_tlast && kind != TAG_NONE) begin
					end_d = 1'b1;
					tag_d = kind;
				end
			end else if (key_len_q < KEY_SAT_V) begin
				for (int i = 0; i < NAME_CNT; i++) begin
					if (key_len_q < NAME_LEN[i] && name_char(i, key_len_q) != upper_c) begin
						match_d[i] = 1'b0;
					end
				end
				key_len_d = key_len_q + 1'b1;
			end
		end else if (s_axis_tdata == CH_SEMI) begin
			if (cur_tag_q != TAG_NONE) begin
				end_d = 1'b1;
				tag_d = cur_tag_q;
			end
			in_value_d = 1'b0;
			key_len_d  = '0;
			match_d    = '1;
			cur_tag_d  = TAG_NONE;
		end else if (cur_tag_q != TAG_NONE) begin
			valid_d = 1'b1;
			tag_d   = cur_tag_q;
			end_d   = s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_q <= 1'b0;
			key_len_q  <= '0;
			match_q    <= '1;
			cur_tag_q  <= TAG_NONE;
			flags_q    <= '0;
		end else if (s_accept) begin
			if (s_axis_tlast) begin
				in_value_q <= 1'b0;
				key_len_q  <= '0;
				match_q    <= '1;
				cur_tag_q  <= TAG_NONE;
				flags_q    <= '0;
			end else begin
				in_value_q <= in_value_d;
				key_len_q  <= key_len_d;
				match_q    <= match_d;
				cur_tag_q  <= cur_tag_d;
				flags_q    <= flags_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			out_byte_q  <= s_axis_tdata;
			out_tag_q   <= tag_d;
			out_vval_q  <= valid_d;
			out_vend_q  <= end_d;
			out_last_q  <= s_axis_tlast;
			out_flags_q <= flags_d;
			out_cpl_q   <= s_axis_tlast && flags_d[0] && flags_d[1];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_cpl_q, out_flags_q, out_byte_q};
	assign m_axis_tuser  = {out_vend_q, out_vval_q, 2'(out_tag_q)};
	assign m_axis_tlast  = out_last_q;

	// a tag is only shown on value bytes or value ends
	a_tag_only_on_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1:0] != 2'd0) |-> (m_axis_tuser[2] || m_axis_tuser[3]))
		else $error("field tag without value byte or value end");

	a_complete_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[11]) |-> (m_axis_tlast && m_axis_tdata[8] && m_axis_tdata[9]))
		else $error("id complete outside last item or without both fields");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_axis_tlast) |=> (flags_q == 3'd0 && !in_value_q && key_len_q == '0))
		else $error("scan state not cleared after last item");

	a_key_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		key_len_q <= KEY_SAT_V)
		else $error("key length beyond saturation");

endmodule
